[sv/bkms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bkms_pkg;

  // Field widths of the item channels and the configuration register
  localparam int FUNC_W  = 2;
  localparam int HASH_W  = 32;
  localparam int RANK_W  = 10;
  localparam int COUNT_W = 11;
  localparam int SIZE_W  = 11;

  // Default sizing
  localparam int CAPACITY_DEF  = 1024;
  localparam int HASH_BITS_DEF = 32;

  // Fan-in of one node of the registered reduction tree
  localparam int TREE_FANIN = 32;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // Sketch size after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic              shift_en;
    logic [RANK_W-1:0] rank;
  } bkms_cell_ctl_t;

  // Number of nodes at a given level of the tree (level 0 is the leaves)
  function automatic int tree_nodes(int n, int lvl);
    int m;
    m = n;
    for (int i = 0; i < lvl; i++) begin
      m = (m + TREE_FANIN - 1) / TREE_FANIN;
    end
    return m;
  endfunction

  // Number of registered levels needed to reduce n leaves to one node
  function automatic int tree_levels(int n);
    int m;
    int l;
    m = n;
    l = 0;
    while (m > 1) begin
      m = (m + TREE_FANIN - 1) / TREE_FANIN;
      l++;
    end
    return l;
  endfunction

endpackage

`default_nettype wire

[sv/bkms_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Input item channel
interface bkms_in_if;
  import bkms_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [HASH_W-1:0] hash_value;
  logic [RANK_W-1:0] read_rank;

  modport source (output valid, func, hash_value, read_rank, input ready);
  modport sink   (input valid, func, hash_value, read_rank, output ready);
endinterface

// Result item channel
interface bkms_out_if;
  import bkms_pkg::*;
  logic               valid;
  logic               ready;
  logic               inserted;
  logic [HASH_W-1:0]  read_value;
  logic               read_valid;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, inserted, read_value, read_valid, entry_count, input ready);
  modport sink   (input valid, inserted, read_value, read_valid, entry_count, output ready);
endinterface

`default_nettype wire

[sv/bkms_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted chain. Holds the entry at rank IDX and shifts it
// to the right neighbor when a smaller hash is inserted in front of it.
module bkms_cell #(
  parameter int IDX = 0,
  parameter int CW  = 11,
  parameter int SW  = 32,
  parameter int IW  = 10
) (
  input  logic                     clk,
  input  bkms_pkg::bkms_cell_ctl_t ctl_i,
  input  logic [CW-1:0]            count_i,
  input  logic [SW-1:0]            h_i,
  input  logic [SW-1:0]            left_val_i,
  input  logic                     left_lt_i,
  output logic [SW-1:0]            val_o,
  output logic                     lt_o,
  output logic [SW+1:0]            leaf_o
);
  import bkms_pkg::*;

  logic [SW-1:0] val_r;
  logic [SW-1:0] val_nxt;
  logic          vld;
  logic          lt;
  logic          hit;
  logic          gt;
  logic          sel;

  // Occupancy follows from the held count: entries fill ranks from zero
  assign vld = (CW'(IDX) < count_i);
  assign lt  = vld && (val_r < h_i);
  assign hit = vld && (val_r == h_i);
  assign gt  = vld && (val_r > h_i);
  assign sel = vld && (IW'(ctl_i.rank) == IW'(IDX));

  // Leaf for the reduction tree: duplicate, larger entry, read data
  assign leaf_o = {hit, gt, (sel ? val_r : '0)};
  assign val_o  = val_r;
  assign lt_o   = lt;

  // Take the new hash at the insert point, shift behind it, hold before it
  always_comb begin
    val_nxt = val_r;
    if (ctl_i.shift_en) begin
      if (!left_lt_i) begin
        val_nxt = left_val_i;
      end else if (!lt) begin
        val_nxt = h_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

[sv/bkms_or_tree.sv]
`timescale 1ns / 1ps
`default_nettype none

// Registered OR tree over the cell leaves, one level per cycle
module bkms_or_tree #(
  parameter int N = 1024,
  parameter int W = 34
) (
  input  logic         clk,
  input  logic [W-1:0] leaf_i [N],
  output logic [W-1:0] root_o
);
  import bkms_pkg::*;

  localparam int LEVELS = tree_levels(N);

  logic [W-1:0] lvl_r   [LEVELS][N];
  logic [W-1:0] lvl_nxt [LEVELS][N];

  // Combine up to TREE_FANIN nodes of the level below into each node
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      for (int j = 0; j < N; j++) begin
        lvl_nxt[l][j] = '0;
        if (j < tree_nodes(N, l + 1)) begin
          for (int m = 0; m < TREE_FANIN; m++) begin
            if (j * TREE_FANIN + m < tree_nodes(N, l)) begin
              if (l == 0) begin
                lvl_nxt[l][j] = lvl_nxt[l][j] | leaf_i[j * TREE_FANIN + m];
              end else begin
                lvl_nxt[l][j] = lvl_nxt[l][j] | lvl_r[l - 1][j * TREE_FANIN + m];
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
  end

  assign root_o = lvl_r[LEVELS - 1][0];

endmodule

`default_nettype wire

[sv/bottom_k_minhash_sketch_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Bottom-k MinHash sketch: keeps the k smallest distinct hashes, sorted.
// Channels: in_ch carries one item (func insert/read/clear, hash_value,
// read_rank); out_ch returns exactly one result item per input item, in
// order. cfg_we/cfg_wdata write k (sketch_size); write only while idle.
// The entries sit in a chain of CAPACITY cells; an insert compares the hash
// in every cell at once and shifts the cells behind the insert point one
// place to the right. Duplicate, larger-entry and read-data flags are
// gathered by a registered OR tree of fan-in 32 with LEVELS levels
// (2 for CAPACITY 1024).
// An accepted item is registered, reduced through the tree levels, then applied
// and its result loaded into the output register; items are processed one at a
// time, and the next item is taken only once the previous one is applied.
// A pending result sits in an output register, so the next item is taken
// while the receiver stalls; that item then waits before its update until
// the previous result is taken.
// Reset empties the sketch and sets k to 1024; no clearing pass is needed.
module bottom_k_minhash_sketch_unit #(
  parameter int CAPACITY  = bkms_pkg::CAPACITY_DEF,
  parameter int HASH_BITS = bkms_pkg::HASH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bkms_pkg::SIZE_W-1:0] cfg_wdata,
  bkms_in_if.sink                     in_ch,
  bkms_out_if.source                  out_ch
);
  import bkms_pkg::*;

  localparam int SW     = (HASH_BITS < HASH_W) ? HASH_BITS : HASH_W;
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int CIW    = $clog2(CAPACITY);
  localparam int IW     = (CIW > RANK_W) ? CIW : RANK_W;
  localparam int KW     = (CW > SIZE_W) ? CW : SIZE_W;
  localparam int RW     = (CW > IW) ? CW : IW;
  localparam int TW     = SW + 2;
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REDUCE = 2'd1;
  localparam logic [1:0] S_APPLY  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [LW-1:0]      wait_r, wait_nxt;
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [SW-1:0]      h_r, h_nxt;
  logic [RANK_W-1:0]  rank_r, rank_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               ins_r, ins_nxt;
  logic [HASH_W-1:0]  rval_r, rval_nxt;
  logic               rvalid_r, rvalid_nxt;
  logic [COUNT_W-1:0] cnt_out_r, cnt_out_nxt;

  logic               in_fire;
  logic               apply_fire;
  logic [KW-1:0]      keff;
  logic               grow;
  logic               found;
  logic               gt_any;
  logic [SW-1:0]      rdata;
  logic               do_ins;
  logic               rd_ok;
  logic [TW-1:0]      root;
  bkms_cell_ctl_t     ctl;

  logic [SW-1:0]      val_w  [CAPACITY];
  logic               lt_w   [CAPACITY];
  logic [TW-1:0]      leaf_w [CAPACITY];

  // Chain of cells; cell 0 sees a virtual smaller neighbor
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    if (gi == 0) begin : g_head
      bkms_cell #(.IDX(gi), .CW(CW), .SW(SW), .IW(IW)) u_cell (
        .clk       (clk),
        .ctl_i     (ctl),
        .count_i   (count_r),
        .h_i       (h_r),
        .left_val_i(h_r),
        .left_lt_i (1'b1),
        .val_o     (val_w[gi]),
        .lt_o      (lt_w[gi]),
        .leaf_o    (leaf_w[gi])
      );
    end else begin : g_body
      bkms_cell #(.IDX(gi), .CW(CW), .SW(SW), .IW(IW)) u_cell (
        .clk       (clk),
        .ctl_i     (ctl),
        .count_i   (count_r),
        .h_i       (h_r),
        .left_val_i(val_w[gi - 1]),
        .left_lt_i (lt_w[gi - 1]),
        .val_o     (val_w[gi]),
        .lt_o      (lt_w[gi]),
        .leaf_o    (leaf_w[gi])
      );
    end
  end

  bkms_or_tree #(.N(CAPACITY), .W(TW)) u_tree (
    .clk   (clk),
    .leaf_i(leaf_w),
    .root_o(root)
  );

  assign found  = root[TW-1];
  assign gt_any = root[TW-2];
  assign rdata  = root[SW-1:0];

  // Handshakes
  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign apply_fire         = (state_r == S_APPLY) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.inserted    = ins_r;
  assign out_ch.read_value  = rval_r;
  assign out_ch.read_valid  = rvalid_r;
  assign out_ch.entry_count = cnt_out_r;

  // Decide the item once the tree has settled
  assign keff   = (KW'(size_r) > KW'(CAPACITY)) ? KW'(CAPACITY) : KW'(size_r);
  assign grow   = (KW'(count_r) < keff);
  assign do_ins = (func_r == FUNC_INSERT) && !found && (grow || gt_any);
  assign rd_ok  = (func_r == FUNC_READ) && (RW'(rank_r) < RW'(count_r));

  assign ctl.shift_en = apply_fire && do_ins;
  assign ctl.rank     = rank_r;

  always_comb begin
    state_nxt     = state_r;
    wait_nxt      = wait_r;
    func_nxt      = func_r;
    h_nxt         = h_r;
    rank_nxt      = rank_r;
    count_nxt     = count_r;
    size_nxt      = cfg_we ? cfg_wdata : size_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ins_nxt       = ins_r;
    rval_nxt      = rval_r;
    rvalid_nxt    = rvalid_r;
    cnt_out_nxt   = cnt_out_r;

    case (state_r)
      S_IDLE: begin
        // Latch the item and start the tree
        if (in_fire) begin
          func_nxt  = in_ch.func;
          h_nxt     = SW'(in_ch.hash_value);
          rank_nxt  = in_ch.read_rank;
          wait_nxt  = LW'(LEVELS - 1);
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        // Wait for the tree root
        if (wait_r == '0) begin
          state_nxt = S_APPLY;
        end else begin
          wait_nxt = wait_r - 1'b1;
        end
      end
      S_APPLY: begin
        // Update the count and load the result once the output slot frees
        if (apply_fire) begin
          if (func_r == FUNC_CLEAR) begin
            count_nxt = '0;
          end else if (do_ins && grow) begin
            count_nxt = count_r + 1'b1;
          end
          out_valid_nxt = 1'b1;
          ins_nxt       = do_ins;
          rval_nxt      = rd_ok ? HASH_W'(rdata) : '0;
          rvalid_nxt    = rd_ok;
          cnt_out_nxt   = COUNT_W'(count_nxt);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      size_r      <= SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wait_r    <= wait_nxt;
    func_r    <= func_nxt;
    h_r       <= h_nxt;
    rank_r    <= rank_nxt;
    ins_r     <= ins_nxt;
    rval_r    <= rval_nxt;
    rvalid_r  <= rvalid_nxt;
    cnt_out_r <= cnt_out_nxt;
  end

endmodule

`default_nettype wire

[sv/bkms_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the result channel
module bkms_checker #(
  parameter int CAPACITY = bkms_pkg::CAPACITY_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         inserted,
  input wire logic [bkms_pkg::HASH_W-1:0]  read_value,
  input wire logic                         read_valid,
  input wire logic [bkms_pkg::COUNT_W-1:0] entry_count
);
  import bkms_pkg::*;

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Never hold more entries than the chain has cells
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(entry_count) <= CAPACITY))
    else $error("entry count above capacity");

  // An inserted hash leaves a non-empty sketch and is no read
  a_ins_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && inserted |-> (entry_count != '0) && !read_valid)
    else $error("insert reported with empty sketch or read flag");

  // Invalid reads return zero
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !read_valid |-> (read_value == '0))
    else $error("non-zero read value without read_valid");

endmodule

bind bottom_k_minhash_sketch_unit bkms_checker #(.CAPACITY(CAPACITY)) u_bkms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .inserted   (out_ch.inserted),
  .read_value (out_ch.read_value),
  .read_valid (out_ch.read_valid),
  .entry_count(out_ch.entry_count)
);

`default_nettype wire
